@@ src/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// shared constants, payload structs, controller states and the command and
// status bundles between the lfu controller and datapath
// ----------------------------------------------------------------------------
package lfu_pkg;

	// storage geometry
	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 64;
	localparam int VALUE_BITS = 32;
	localparam int COUNT_BITS = 16;

	// derived widths
	localparam int IDX_BITS  = $clog2(ENTRIES);
	localparam int OCC_BITS  = $clog2(ENTRIES + 1);
	localparam int CAP_BITS  = 5;
	localparam int WIDE_BITS = (CAP_BITS > OCC_BITS) ? CAP_BITS : OCC_BITS;

	// port field widths
	localparam int KEY_W  = 64;
	localparam int WVAL_W = 32;
	localparam int RVAL_W = 32;

	// configuration port
	localparam int APB_DATA_BITS = 32;
	localparam int APB_ADDR_BITS = 3;
	localparam logic REG_CAPACITY = 1'b0;
	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	// request codes
	localparam logic REQ_GET = 1'b0;
	localparam logic REQ_SET = 1'b1;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	typedef struct packed {
		logic              req_type;
		logic [KEY_W-1:0]  key;
		logic [WVAL_W-1:0] write_value;
	} lfu_req_t;

	typedef struct packed {
		logic              hit;
		logic [RVAL_W-1:0] read_value;
		logic              evicted;
	} lfu_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HIT,
		ST_VWAIT,
		ST_EVICT,
		ST_INSERT,
		ST_RESP
	} lfu_state_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic hit_upd;
		logic capture;
		logic evict;
		logic insert;
	} lfu_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic match_found;
		logic is_set;
		logic need_evict;
		logic free_found;
		logic disabled;
	} lfu_stat_t;

endpackage

@@ src/lfu_ram.sv @@
// ----------------------------------------------------------------------------
// lfu_ram
// generic single-port ram, one write or read a cycle, registered read data
// ----------------------------------------------------------------------------
module lfu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ src/lfu_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfu_ctrl
// request sequencer: scan, hit update, eviction, insertion and result strobe
// ----------------------------------------------------------------------------
module lfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  lfu_pkg::lfu_stat_t stat,
	output lfu_pkg::lfu_cmd_t  cmd,
	output logic              busy,
	output logic              done
);
	import lfu_pkg::*;

	lfu_state_t state_q;
	lfu_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = stat.disabled ? ST_RESP : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					if (stat.match_found) begin
						state_nxt = ST_HIT;
					end else if (!stat.is_set) begin
						state_nxt = ST_RESP;
					end else if (stat.need_evict) begin
						state_nxt = ST_EVICT;
					end else if (stat.free_found) begin
						state_nxt = ST_INSERT;
					end else begin
						state_nxt = ST_RESP;
					end
				end
			end
			ST_HIT:    state_nxt = stat.is_set ? ST_RESP : ST_VWAIT;
			ST_VWAIT:  state_nxt = ST_RESP;
			ST_EVICT:  state_nxt = ST_INSERT;
			ST_INSERT: state_nxt = ST_RESP;
			ST_RESP:   state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SCAN:   cmd.scan    = 1'b1;
			ST_HIT:    cmd.hit_upd = 1'b1;
			ST_VWAIT:  cmd.capture = 1'b1;
			ST_EVICT:  cmd.evict   = 1'b1;
			ST_INSERT: cmd.insert  = 1'b1;
			ST_RESP:   done        = 1'b1;
			default:   busy        = 1'b1;
		endcase
	end

endmodule

@@ src/lfu_dp.sv @@
// ----------------------------------------------------------------------------
// lfu_dp
// key and value memories, per-entry valid, use count and recency rank, scan
// compare stage and result register
// ----------------------------------------------------------------------------
module lfu_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lfu_pkg::lfu_cmd_t             cmd,
	input  lfu_pkg::lfu_req_t             req,
	input  logic [lfu_pkg::CAP_BITS-1:0]  cap,
	output lfu_pkg::lfu_stat_t            stat,
	output lfu_pkg::lfu_rsp_t             rsp
);
	import lfu_pkg::*;

	// per-entry state
	logic                  valid_q [ENTRIES];
	logic [COUNT_BITS-1:0] count_q [ENTRIES];
	logic [IDX_BITS-1:0]   rank_q  [ENTRIES];
	logic [OCC_BITS-1:0]   occ_q;

	// request and result
	lfu_req_t req_q;
	lfu_rsp_t res_q;

	// scan pipeline
	logic [OCC_BITS-1:0] rd_idx_q;
	logic                issue;
	logic                cmp_vld_s1;
	logic [IDX_BITS-1:0] idx_s1;

	// scan findings
	logic                  match_found_q;
	logic [IDX_BITS-1:0]   match_idx_q;
	logic [IDX_BITS-1:0]   match_rank_q;
	logic [COUNT_BITS-1:0] match_count_q;
	logic                  vic_found_q;
	logic [IDX_BITS-1:0]   vic_idx_q;
	logic [IDX_BITS-1:0]   vic_rank_q;
	logic [COUNT_BITS-1:0] vic_count_q;
	logic                  free_found_q;
	logic [IDX_BITS-1:0]   free_idx_q;

	// compare stage
	logic                  cv;
	logic [COUNT_BITS-1:0] cc;
	logic [IDX_BITS-1:0]   cr;
	logic                  key_eq;
	logic                  take_match;
	logic                  take_vic;
	logic                  take_free;

	// memories
	logic                  kram_we;
	logic [IDX_BITS-1:0]   kram_addr;
	logic [KEY_BITS-1:0]   kram_rdata;
	logic                  vram_we;
	logic [IDX_BITS-1:0]   vram_addr;
	logic [VALUE_BITS-1:0] vram_rdata;

	// insertion
	logic                  ins_ok;
	logic [IDX_BITS-1:0]   ins_slot;
	logic [WIDE_BITS-1:0]  eff_cap;
	logic [COUNT_BITS-1:0] bumped;

	assign issue = cmd.scan && (rd_idx_q < OCC_BITS'(ENTRIES));

	assign cv     = valid_q[idx_s1];
	assign cc     = count_q[idx_s1];
	assign cr     = rank_q[idx_s1];
	assign key_eq = (kram_rdata == req_q.key[KEY_BITS-1:0]);

	assign take_match = cmp_vld_s1 && cv && key_eq && !match_found_q;
	assign take_vic   = cmp_vld_s1 && cv && (!vic_found_q || (cc < vic_count_q) ||
		((cc == vic_count_q) && (cr > vic_rank_q)));
	assign take_free  = cmp_vld_s1 && !cv && !free_found_q;

	// after an eviction the lowest free index wins
	assign ins_ok   = res_q.evicted || free_found_q;
	assign ins_slot = (res_q.evicted && !(free_found_q && (free_idx_q < vic_idx_q))) ?
		vic_idx_q : free_idx_q;

	assign bumped = (match_count_q == COUNT_MAX) ? match_count_q :
		match_count_q + COUNT_BITS'(1);

	assign eff_cap = (WIDE_BITS'(cap) > WIDE_BITS'(ENTRIES)) ? WIDE_BITS'(ENTRIES) :
		WIDE_BITS'(cap);

	assign kram_we   = cmd.insert && ins_ok;
	assign kram_addr = cmd.insert ? ins_slot : rd_idx_q[IDX_BITS-1:0];
	assign vram_we   = (cmd.insert && ins_ok) || (cmd.hit_upd && (req_q.req_type == REQ_SET));
	assign vram_addr = cmd.insert ? ins_slot : match_idx_q;

	lfu_ram #(
		.WIDTH (KEY_BITS),
		.DEPTH (ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (kram_we),
		.addr  (kram_addr),
		.wdata (req_q.key[KEY_BITS-1:0]),
		.rdata (kram_rdata)
	);

	lfu_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (ENTRIES)
	) u_value_ram (
		.clk   (clk),
		.we    (vram_we),
		.addr  (vram_addr),
		.wdata (req_q.write_value[VALUE_BITS-1:0]),
		.rdata (vram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q      <= '0;
			cmp_vld_s1    <= 1'b0;
			match_found_q <= 1'b0;
			vic_found_q   <= 1'b0;
			free_found_q  <= 1'b0;
			occ_q         <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				count_q[i] <= '0;
				rank_q[i]  <= '0;
			end
		end else begin
			cmp_vld_s1 <= issue;
			if (cmd.load) begin
				rd_idx_q      <= '0;
				match_found_q <= 1'b0;
				vic_found_q   <= 1'b0;
				free_found_q  <= 1'b0;
			end else begin
				if (issue) begin
					rd_idx_q <= rd_idx_q + OCC_BITS'(1);
				end
				if (take_match) begin
					match_found_q <= 1'b1;
				end
				if (take_vic) begin
					vic_found_q <= 1'b1;
				end
				if (take_free) begin
					free_found_q <= 1'b1;
				end
			end

			// move the hit entry to the front of the recency order
			if (cmd.hit_upd) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && (IDX_BITS'(i) != match_idx_q) &&
						(rank_q[i] < match_rank_q)) begin
						rank_q[i] <= rank_q[i] + IDX_BITS'(1);
					end
				end
				rank_q[match_idx_q]  <= '0;
				count_q[match_idx_q] <= bumped;
			end

			// drop the victim and close the gap in the ranks
			if (cmd.evict && vic_found_q) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i] && (rank_q[i] > vic_rank_q)) begin
						rank_q[i] <= rank_q[i] - IDX_BITS'(1);
					end
				end
				valid_q[vic_idx_q] <= 1'b0;
				if (occ_q != '0) begin
					occ_q <= occ_q - OCC_BITS'(1);
				end
			end

			// new entry becomes most recent, all others age by one
			if (cmd.insert && ins_ok) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + IDX_BITS'(1);
					end
				end
				valid_q[ins_slot] <= 1'b1;
				count_q[ins_slot] <= COUNT_BITS'(1);
				rank_q[ins_slot]  <= '0;
				occ_q             <= occ_q + OCC_BITS'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_BITS-1:0];
		if (cmd.load) begin
			req_q <= req;
			res_q <= '0;
		end
		if (take_match) begin
			match_idx_q   <= idx_s1;
			match_rank_q  <= cr;
			match_count_q <= cc;
		end
		if (take_vic) begin
			vic_idx_q   <= idx_s1;
			vic_rank_q  <= cr;
			vic_count_q <= cc;
		end
		if (take_free) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.hit_upd) begin
			res_q.hit <= 1'b1;
		end
		if (cmd.capture) begin
			res_q.read_value <= RVAL_W'(vram_rdata);
		end
		if (cmd.evict && vic_found_q) begin
			res_q.evicted <= 1'b1;
		end
	end

	assign stat.scan_done   = (rd_idx_q == OCC_BITS'(ENTRIES)) && !cmp_vld_s1;
	assign stat.match_found = match_found_q;
	assign stat.is_set      = (req_q.req_type == REQ_SET);
	assign stat.need_evict  = (WIDE_BITS'(occ_q) >= eff_cap);
	assign stat.free_found  = free_found_q;
	assign stat.disabled    = (eff_cap == '0);

	assign rsp = res_q;

endmodule

@@ src/lfu_cache_lru_tiebreak.sv @@
// ----------------------------------------------------------------------------
// lfu_cache_lru_tiebreak
// fully associative key/value cache, least-frequently-used replacement with
// least-recently-used tie-break, apb capacity register
// ----------------------------------------------------------------------------
// a request is taken when start is high and busy is low; its single result
// appears on rsp for exactly one cycle with done high and cannot be held off,
// so the receiver must sample it on that cycle. busy stays high from the
// accepting edge until the result cycle has passed: a get miss scans, a get
// hit also updates the entry and captures its value, a set also updates,
// evicts or inserts, a request with the cache disabled goes straight to its
// result. the scan reads the key memory one entry per cycle through a single
// read port and finds the matching key, the victim and the first free slot in
// one pass. capacity_in_use is at byte address 0 and is meant to be written
// only while busy is low; values above ENTRIES act as ENTRIES, 0 disables.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak (
	input  logic                                clk,
	input  logic                                arst_n,
	// request channel
	input  logic                                start,
	output logic                                busy,
	input  lfu_pkg::lfu_req_t                   req,
	// result channel
	output logic                                done,
	output lfu_pkg::lfu_rsp_t                   rsp,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [lfu_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [lfu_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [lfu_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                pready
);
	import lfu_pkg::*;

	// capacity register
	logic [CAP_BITS-1:0] cap_q;
	logic                cfg_wr;

	// controller to datapath bundles
	lfu_cmd_t  cmd;
	lfu_stat_t stat;

	// zero wait state port
	assign pready = 1'b1;

	// write completes on the access phase; word address is paddr[2]
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
			cap_q <= pwdata[CAP_BITS-1:0];
		end
	end

	// register read-back
	always_comb begin
		unique case (paddr[2])
			REG_CAPACITY: prdata = APB_DATA_BITS'(cap_q);
			default:      prdata = '0;
		endcase
	end

	// sequencer: walks each transaction through scan, update and result
	lfu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// storage, scan compare and replacement bookkeeping
	lfu_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.cap    (cap_q),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
